// ===== sv/dpb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dpb_pkg: shared types and constants for depth pixel back-projection
// Frame geometry, register map, config bundle and queue word layout.
// ----------------------------------------------------------------------------
package dpb_pkg;

   // frame geometry limits
   localparam int MAX_WIDTH   = 640;
   localparam int MAX_HEIGHT  = 480;
   localparam int FRAME_WORDS = MAX_WIDTH * MAX_HEIGHT;
   localparam int MEM_AW      = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
   localparam int COL_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WID_W       = $clog2(MAX_WIDTH + 1);

   // queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // register map (word index)
   localparam int CSR_AW = 5;
   localparam logic [2:0] REG_INV_FOCAL_X  = 3'd0;
   localparam logic [2:0] REG_INV_FOCAL_Y  = 3'd1;
   localparam logic [2:0] REG_CENTER_X     = 3'd2;
   localparam logic [2:0] REG_CENTER_Y     = 3'd3;
   localparam logic [2:0] REG_DEPTH_SCALE  = 3'd4;
   localparam logic [2:0] REG_FRAME_WIDTH  = 3'd5;
   localparam logic [2:0] REG_FRAME_HEIGHT = 3'd6;

   localparam logic [23:0] RST_INV_FOCAL_X  = 24'd32432;
   localparam logic [23:0] RST_INV_FOCAL_Y  = 24'd32482;
   localparam logic [15:0] RST_CENTER_X     = 16'd5098;
   localparam logic [15:0] RST_CENTER_Y     = 16'd4085;
   localparam logic [23:0] RST_DEPTH_SCALE  = 24'd3355;
   localparam logic [9:0]  RST_FRAME_WIDTH  = 10'd640;
   localparam logic [8:0]  RST_FRAME_HEIGHT = 9'd480;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic [23:0] inv_focal_x;
      logic [23:0] inv_focal_y;
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [23:0] depth_scale_recip;
      logic [9:0]  frame_width;
      logic [8:0]  frame_height;
   } cfg_type;

   // one queue word: a pixel write or a query with its memory address
   typedef struct packed {
      logic              is_query;
      logic [MEM_AW-1:0] addr;
      logic [15:0]       raw;
      logic [17:0]       dx;      // point_x - center_x, two's complement Q.4
      logic [17:0]       dy;
   } q_entry_type;

endpackage
`default_nettype wire

// ===== sv/dpb_csr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dpb_csr: configuration registers
// APB-style register file holding camera intrinsics and frame size.
// ----------------------------------------------------------------------------
module dpb_csr
   import dpb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   cfg_type    cfg_ff;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_AW-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_focal_x       <= RST_INV_FOCAL_X;
         cfg_ff.inv_focal_y       <= RST_INV_FOCAL_Y;
         cfg_ff.center_x          <= RST_CENTER_X;
         cfg_ff.center_y          <= RST_CENTER_Y;
         cfg_ff.depth_scale_recip <= RST_DEPTH_SCALE;
         cfg_ff.frame_width       <= RST_FRAME_WIDTH;
         cfg_ff.frame_height      <= RST_FRAME_HEIGHT;
      end else if (wr_en) begin
         case (reg_idx)
            REG_INV_FOCAL_X:  cfg_ff.inv_focal_x       <= pwdata[23:0];
            REG_INV_FOCAL_Y:  cfg_ff.inv_focal_y       <= pwdata[23:0];
            REG_CENTER_X:     cfg_ff.center_x          <= pwdata[15:0];
            REG_CENTER_Y:     cfg_ff.center_y          <= pwdata[15:0];
            REG_DEPTH_SCALE:  cfg_ff.depth_scale_recip <= pwdata[23:0];
            REG_FRAME_WIDTH:  cfg_ff.frame_width       <= pwdata[9:0];
            REG_FRAME_HEIGHT: cfg_ff.frame_height      <= pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_INV_FOCAL_X:  prdata = {8'd0, cfg_ff.inv_focal_x};
         REG_INV_FOCAL_Y:  prdata = {8'd0, cfg_ff.inv_focal_y};
         REG_CENTER_X:     prdata = {16'd0, cfg_ff.center_x};
         REG_CENTER_Y:     prdata = {16'd0, cfg_ff.center_y};
         REG_DEPTH_SCALE:  prdata = {8'd0, cfg_ff.depth_scale_recip};
         REG_FRAME_WIDTH:  prdata = {22'd0, cfg_ff.frame_width};
         REG_FRAME_HEIGHT: prdata = {23'd0, cfg_ff.frame_height};
         default:          prdata = 32'd0;
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/dpb_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dpb_front: input stage
// Takes request words, drops out-of-range writes, rounds and clamps query
// points to a pixel and forms the frame address and center offsets.
// ----------------------------------------------------------------------------
module dpb_front
   import dpb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  cfg_type          cfg,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_cmd,
   input  wire logic [18:0] req_pixel_address,
   input  wire logic [15:0] req_raw_depth,
   input  wire logic [15:0] req_point_x,
   input  wire logic [15:0] req_point_y,
   input  wire logic        q_full,
   output logic             q_push,
   output q_entry_type      q_push_entry
);

   localparam int PROD_W = ROW_W + WID_W;

   // Q12.4 to pixel, round half away from zero, clamp to [0, size-1]
   function automatic logic [31:0] pick_pixel(input logic [15:0] q, input logic [31:0] size);
      logic [15:0] s;
      logic [31:0] r;
      s = {1'b0, q[14:0]} + 16'd8;
      r = 32'(s[15:4]);
      if (q[15])
         return 32'd0;
      return (r > size - 32'd1) ? size - 32'd1 : r;
   endfunction

   function automatic logic [31:0] clamp_size(input logic [31:0] v, input int hi);
      if (v == 32'd0)
         return 32'd1;
      return (v > 32'(hi)) ? 32'(hi) : v;
   endfunction

   logic [31:0] w32, h32, wr_addr32;
   logic [31:0] col32, row32;
   logic        wr_ok, en_f;
   logic [WID_W-1:0]  w_cur;
   logic [PROD_W-1:0] addr_prod;

   logic              v_ff;
   logic              is_query_ff;
   logic [MEM_AW-1:0] wr_addr_ff;
   logic [15:0]       raw_ff;
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [17:0]       dx_ff, dy_ff;

   assign w32       = clamp_size(32'(cfg.frame_width), MAX_WIDTH);
   assign h32       = clamp_size(32'(cfg.frame_height), MAX_HEIGHT);
   assign w_cur     = WID_W'(w32);
   assign wr_addr32 = 32'(req_pixel_address);
   assign wr_ok     = wr_addr32 < 32'(FRAME_WORDS);
   assign col32     = pick_pixel(req_point_x, w32);
   assign row32     = pick_pixel(req_point_y, h32);

   assign q_push    = v_ff && !q_full;
   assign en_f      = !v_ff || !q_full;
   assign req_ready = en_f;

   always_ff @(posedge clock) begin
      if (reset)
         v_ff <= 1'b0;
      else if (en_f)
         v_ff <= req_valid && (req_cmd == CMD_QUERY || wr_ok);
   end

   always_ff @(posedge clock) begin
      if (en_f) begin
         is_query_ff <= (req_cmd == CMD_QUERY);
         wr_addr_ff  <= MEM_AW'(wr_addr32);
         raw_ff      <= req_raw_depth;
         col_ff      <= COL_W'(col32);
         row_ff      <= ROW_W'(row32);
         dx_ff       <= {{2{req_point_x[15]}}, req_point_x} - {2'b00, cfg.center_x};
         dy_ff       <= {{2{req_point_y[15]}}, req_point_y} - {2'b00, cfg.center_y};
      end
   end

   assign addr_prod = PROD_W'(row_ff) * PROD_W'(w_cur) + PROD_W'(col_ff);

   always_comb begin
      q_push_entry.is_query = is_query_ff;
      q_push_entry.addr     = is_query_ff ? MEM_AW'(addr_prod) : wr_addr_ff;
      q_push_entry.raw      = raw_ff;
      q_push_entry.dx       = dx_ff;
      q_push_entry.dy       = dy_ff;
   end

endmodule
`default_nettype wire

// ===== sv/dpb_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dpb_queue: command queue
// Small FIFO that decouples the input stage from the memory and math stage.
// ----------------------------------------------------------------------------
module dpb_queue
   import dpb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  q_entry_type        push_entry,
   input  wire logic          pop,
   output logic               q_valid,
   output q_entry_type        head,
   output logic               q_full,
   output logic [Q_CNT_W-1:0] q_count
);

   q_entry_type        slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0] count_ff;

   assign q_valid = count_ff != '0;
   assign q_full  = count_ff == Q_CNT_W'(Q_DEPTH);
   assign q_count = count_ff;
   assign head    = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)
            rd_ptr_ff <= (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         if (push && !pop)
            count_ff <= count_ff + 1'b1;
         else if (pop && !push)
            count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule
`default_nettype wire

// ===== sv/dpb_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dpb_back: frame memory and projection pipeline
// Writes depth pixels, reads them for queries, scales to Z and forms X, Y
// with split wide products; holds the result word in the output register.
// ----------------------------------------------------------------------------
module dpb_back
   import dpb_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  cfg_type     cfg,
   input  wire logic   q_valid,
   input  q_entry_type q_head,
   output logic        q_pop,
   output logic        rsp_valid,
   input  wire logic   rsp_ready,
   output logic [31:0] rsp_pos_x,
   output logic [31:0] rsp_pos_y,
   output logic [30:0] rsp_pos_z
);

   // rounded Q.36 magnitude to saturated signed Q16.16
   function automatic logic [31:0] finish(input logic neg, input logic [46:0] ph,
                                          input logic [47:0] pl);
      logic [63:0] sum;
      logic [43:0] mag;
      sum = {ph[46:0], 17'd0} + 64'(pl) + 64'(20'h80000);
      mag = sum[63:20];
      if (neg)
         return (mag >= 44'h0_8000_0000) ? 32'h8000_0000 : 32'd0 - mag[31:0];
      return (mag > 44'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
   endfunction

   logic [15:0] frame_mem [FRAME_WORDS];

   logic pop_write, pop_query;
   logic en1, en2, en3, en4;

   // stage 1: memory read
   logic        v1_ff;
   logic [15:0] rd_ff;
   logic [17:0] dx1_ff, dy1_ff;

   // stage 2: Z and unit-plane coordinates
   logic        v2_ff;
   logic [30:0] z2_ff;
   logic [32:0] umx2_ff, umy2_ff;
   logic        negx2_ff, negy2_ff;
   logic [39:0] zprod;
   logic [31:0] zsh;
   logic [30:0] z_in;
   logic [16:0] magx, magy;
   logic [40:0] uxprod, uyprod;

   // stage 3: partial products
   logic        v3_ff;
   logic [30:0] z3_ff;
   logic [46:0] phx_ff, phy_ff;
   logic [47:0] plx_ff, ply_ff;
   logic        negx3_ff, negy3_ff;

   // stage 4: output register
   logic        v4_ff;
   logic [31:0] posx_ff, posy_ff;
   logic [30:0] posz_ff;

   assign en4 = !v4_ff || rsp_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   // writes need no pipeline slot
   assign pop_write = q_valid && !q_head.is_query;
   assign pop_query = q_valid && q_head.is_query && en1;
   assign q_pop     = pop_write || pop_query;

   always_ff @(posedge clock) begin
      if (pop_write)
         frame_mem[q_head.addr] <= q_head.raw;
      if (pop_query)
         rd_ff <= frame_mem[q_head.addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= pop_query;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_query) begin
         dx1_ff <= q_head.dx;
         dy1_ff <= q_head.dy;
      end
   end

   assign zprod  = 40'(rd_ff) * 40'(cfg.depth_scale_recip) + 40'd128;
   assign zsh    = zprod[39:8];
   assign z_in   = zsh[31] ? 31'h7FFF_FFFF : zsh[30:0];
   assign magx   = dx1_ff[17] ? 17'(18'd0 - dx1_ff) : dx1_ff[16:0];
   assign magy   = dy1_ff[17] ? 17'(18'd0 - dy1_ff) : dy1_ff[16:0];
   assign uxprod = 41'(magx) * 41'(cfg.inv_focal_x) + 41'd128;
   assign uyprod = 41'(magy) * 41'(cfg.inv_focal_y) + 41'd128;

   always_ff @(posedge clock) begin
      if (en2) begin
         z2_ff    <= z_in;
         umx2_ff  <= uxprod[40:8];
         umy2_ff  <= uyprod[40:8];
         negx2_ff <= dx1_ff[17];
         negy2_ff <= dy1_ff[17];
      end
   end

   // 33 x 31 product split into high and low halves of the 33-bit factor
   always_ff @(posedge clock) begin
      if (en3) begin
         z3_ff    <= z2_ff;
         phx_ff   <= 47'(umx2_ff[32:17]) * 47'(z2_ff);
         plx_ff   <= 48'(umx2_ff[16:0]) * 48'(z2_ff);
         phy_ff   <= 47'(umy2_ff[32:17]) * 47'(z2_ff);
         ply_ff   <= 48'(umy2_ff[16:0]) * 48'(z2_ff);
         negx3_ff <= negx2_ff;
         negy3_ff <= negy2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         posx_ff <= finish(negx3_ff, phx_ff, plx_ff);
         posy_ff <= finish(negy3_ff, phy_ff, ply_ff);
         posz_ff <= z3_ff;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_pos_x = posx_ff;
   assign rsp_pos_y = posy_ff;
   assign rsp_pos_z = posz_ff;

endmodule
`default_nettype wire

// ===== sv/depth_pixel_backprojection_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_top: depth frame store and 3D back-projection
// Request words either write one 16-bit depth pixel (cmd 0) or query a Q12.4
// feature point (cmd 1). Each query returns one response word with X, Y in
// signed Q16.16 and Z in unsigned Q15.16; writes return nothing.
// Channels: req_* and rsp_* use valid/ready; camera intrinsics and frame
// size sit in APB-style registers, to be written by the user only while the
// block is idle; the block itself does not enforce this. Throughput: one
// request word per cycle, writes and queries alike, as long as responses
// are taken. A query passes the input stage, 4-deep queue, memory read,
// Z and unit-plane multiply, split X/Y products and output register.
// A pixel must be written before any query lands on it; writes beyond the
// frame memory are dropped. Queries are clamped to the frame in use.
// Reset clears the pipeline and restores the default camera registers;
// frame memory contents are left as they are (no clearing pass).
// When rsp_ready is low the output register holds, the pipeline and then
// the queue fill, and req_ready drops once the input stage cannot advance.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_top
   import dpb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_cmd,
   input  wire logic [18:0]       req_pixel_address,
   input  wire logic [15:0]       req_raw_depth,
   input  wire logic [15:0]       req_point_x,
   input  wire logic [15:0]       req_point_y,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [31:0]            rsp_pos_x,
   output logic [31:0]            rsp_pos_y,
   output logic [30:0]            rsp_pos_z,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready
);

   cfg_type            cfg;
   logic               q_full, q_push, q_pop, q_valid;
   logic [Q_CNT_W-1:0] q_count;
   q_entry_type        q_push_entry, q_head;

   dpb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dpb_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_pixel_address (req_pixel_address),
      .req_raw_depth     (req_raw_depth),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_push_entry      (q_push_entry)
   );

   dpb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .q_valid    (q_valid),
      .head       (q_head),
      .q_full     (q_full),
      .q_count    (q_count)
   );

   dpb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_pos_x (rsp_pos_x),
      .rsp_pos_y (rsp_pos_y),
      .rsp_pos_z (rsp_pos_z)
   );

   // queue never popped empty
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("queue popped while empty");

   // occupancy tracks the push/pop pair
   assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |=> q_count == $past(q_count) + 1'b1)
      else $error("queue count did not follow a push");

   // clamped query address stays inside the frame memory
   assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_head.is_query) |-> 32'(q_head.addr) < 32'(FRAME_WORDS))
      else $error("query address beyond frame memory");

endmodule
`default_nettype wire

// ===== sim/tb_depth_pixel_backprojection_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_pixel_backprojection_top: self-checking bench for depth back-projection
// Streams depth pixel writes and feature-point queries into the block, predicts
// each X/Y/Z response in a scoreboard and compares it field by field, over
// several camera and frame settings with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_depth_pixel_backprojection_top;
   import dpb_pkg::*;

   localparam int PHASE_ITEMS  = 250;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [30:0] z;
   } point_type;

   class point_scoreboard;
      cfg_type     cfg;
      logic [15:0] depth_shadow [FRAME_WORDS];
      point_type   expected_points [$];
      int          writes;
      int          queries;
      int          mismatches;

      function new();
         cfg.inv_focal_x       = RST_INV_FOCAL_X;
         cfg.inv_focal_y       = RST_INV_FOCAL_Y;
         cfg.center_x          = RST_CENTER_X;
         cfg.center_y          = RST_CENTER_Y;
         cfg.depth_scale_recip = RST_DEPTH_SCALE;
         cfg.frame_width       = RST_FRAME_WIDTH;
         cfg.frame_height      = RST_FRAME_HEIGHT;
         writes     = 0;
         queries    = 0;
         mismatches = 0;
      endfunction

      function void set_register(logic [2:0] idx, logic [31:0] value);
         case (idx)
            REG_INV_FOCAL_X:  cfg.inv_focal_x       = value[23:0];
            REG_INV_FOCAL_Y:  cfg.inv_focal_y       = value[23:0];
            REG_CENTER_X:     cfg.center_x          = value[15:0];
            REG_CENTER_Y:     cfg.center_y          = value[15:0];
            REG_DEPTH_SCALE:  cfg.depth_scale_recip = value[23:0];
            REG_FRAME_WIDTH:  cfg.frame_width       = value[9:0];
            REG_FRAME_HEIGHT: cfg.frame_height      = value[8:0];
            default: ;
         endcase
      endfunction

      function int used_width();
         int w;
         w = int'(cfg.frame_width);
         if (w < 1) w = 1;
         if (w > MAX_WIDTH) w = MAX_WIDTH;
         return w;
      endfunction

      function int used_height();
         int h;
         h = int'(cfg.frame_height);
         if (h < 1) h = 1;
         if (h > MAX_HEIGHT) h = MAX_HEIGHT;
         return h;
      endfunction

      // Q12.4 to whole pixel, half away from zero, clamped to [0, size-1]
      function int round_clamp(logic signed [15:0] q, int size);
         int r;
         if (q < 0) return 0;
         r = (int'(q) + 8) >>> 4;
         return (r > size - 1) ? size - 1 : r;
      endfunction

      function int pixel_index(logic signed [15:0] px, logic signed [15:0] py);
         return round_clamp(py, used_height()) * used_width() + round_clamp(px, used_width());
      endfunction

      function logic [30:0] scale_depth(logic [15:0] raw);
         logic [40:0] acc;
         acc = 41'(raw) * 41'(cfg.depth_scale_recip) + 41'd128;
         if (acc[40:8] > 33'h7FFF_FFFF) return 31'h7FFF_FFFF;
         return acc[38:8];
      endfunction

      // ((p - c) * inv) * z in Q16.16, sign-magnitude rounding, saturated
      function logic [31:0] project_axis(logic signed [15:0] p, logic [15:0] c,
                                         logic [23:0] inv, logic [30:0] z);
         logic signed [17:0] d;
         logic [17:0]        dm;
         logic [42:0]        u_acc;
         logic [34:0]        um;
         logic [65:0]        m_acc;
         logic [45:0]        m;
         d     = {{2{p[15]}}, p} - {2'b00, c};
         dm    = d[17] ? (~d + 18'd1) : d;
         u_acc = 43'(dm) * 43'(inv) + 43'd128;
         um    = u_acc[42:8];
         m_acc = 66'(um) * 66'(z) + 66'd524288;
         m     = m_acc[65:20];
         if (d[17]) begin
            if (m >= 46'h8000_0000) return 32'h8000_0000;
            return ~m[31:0] + 32'd1;
         end
         if (m > 46'h7FFF_FFFF) return 32'h7FFF_FFFF;
         return m[31:0];
      endfunction

      function void note_request(logic cmd, logic [18:0] addr, logic [15:0] raw,
                                 logic signed [15:0] px, logic signed [15:0] py);
         point_type pt;
         if (cmd == CMD_WRITE) begin
            if (addr < FRAME_WORDS) depth_shadow[addr] = raw;
            writes++;
         end else begin
            pt.z = scale_depth(depth_shadow[pixel_index(px, py)]);
            pt.x = project_axis(px, cfg.center_x, cfg.inv_focal_x, pt.z);
            pt.y = project_axis(py, cfg.center_y, cfg.inv_focal_y, pt.z);
            expected_points.insert(expected_points.size(), pt);
            queries++;
         end
      endfunction

      function void check_point(logic [31:0] x, logic [31:0] y, logic [30:0] z);
         point_type pt;
         if (expected_points.size() == 0) begin
            $error("response word with no query pending: x=%h y=%h z=%h", x, y, z);
            mismatches++;
            return;
         end
         pt = expected_points.pop_front();
         if (x !== pt.x) begin
            $error("pos_x: expected %h, got %h", pt.x, x);
            mismatches++;
         end
         if (y !== pt.y) begin
            $error("pos_y: expected %h, got %h", pt.y, y);
            mismatches++;
         end
         if (z !== pt.z) begin
            $error("pos_z: expected %h, got %h", pt.z, z);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_points.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_cmd = CMD_WRITE;
   logic [18:0]       req_pixel_address = '0;
   logic [15:0]       req_raw_depth = '0;
   logic [15:0]       req_point_x = '0;
   logic [15:0]       req_point_y = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [31:0]       rsp_pos_x;
   logic [31:0]       rsp_pos_y;
   logic [30:0]       rsp_pos_z;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   int send_idle_pct = 12;
   int recv_idle_pct = 50;
   int cycles = 0;
   int settings = 1;
   int last_write = 0;
   bit pixel_written [FRAME_WORDS];
   point_scoreboard sb;

   depth_pixel_backprojection_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_pixel_address (req_pixel_address),
      .req_raw_depth     (req_raw_depth),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_pos_z         (rsp_pos_z),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) sb.check_point(rsp_pos_x, rsp_pos_y, rsp_pos_z);

   task automatic push_word(input logic cmd, input logic [18:0] addr, input logic [15:0] raw,
                            input logic [15:0] px, input logic [15:0] py);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_cmd           <= cmd;
      req_pixel_address <= addr;
      req_raw_depth     <= raw;
      req_point_x       <= px;
      req_point_y       <= py;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(cmd, addr, raw, px, py);
   endtask

   task automatic send_write(input logic [18:0] addr, input logic [15:0] raw);
      push_word(CMD_WRITE, addr, raw, 16'($urandom), 16'($urandom));
      if (addr < FRAME_WORDS) begin
         pixel_written[addr] = 1'b1;
         last_write = int'(addr);
      end
   endtask

   // a query never lands on a pixel that was not written: fill it first
   task automatic send_query(input logic signed [15:0] px, input logic signed [15:0] py);
      int idx;
      idx = sb.pixel_index(px, py);
      if (!pixel_written[idx]) send_write(19'(idx), 16'($urandom));
      push_word(CMD_QUERY, 19'($urandom), 16'($urandom), px, py);
   endtask

   // writes cause no response, so give in-flight words time to retire
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.set_register(idx, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic load_camera(input int ifx, input int ify, input int cx, input int cy,
                              input int dsr, input int fw, input int fh);
      wait_idle();
      write_register(REG_INV_FOCAL_X, 32'(ifx));
      write_register(REG_INV_FOCAL_Y, 32'(ify));
      write_register(REG_CENTER_X, 32'(cx));
      write_register(REG_CENTER_Y, 32'(cy));
      write_register(REG_DEPTH_SCALE, 32'(dsr));
      write_register(REG_FRAME_WIDTH, 32'(fw));
      write_register(REG_FRAME_HEIGHT, 32'(fh));
      settings++;
   endtask

   task automatic random_items(input int count);
      int          w;
      int          h;
      int          roll;
      int          ix;
      int          iy;
      logic [18:0] addr;
      logic [15:0] raw;
      for (int i = 0; i < count; i++) begin
         w    = sb.used_width();
         h    = sb.used_height();
         roll = $urandom_range(99);
         if (roll < 45) begin
            addr = ($urandom_range(99) < 85) ? 19'($urandom_range(0, w * h - 1))
                                             : 19'($urandom);
            roll = $urandom_range(9);
            raw  = (roll == 0) ? 16'h0000 : (roll == 1) ? 16'hFFFF : 16'($urandom);
            send_write(addr, raw);
         end else begin
            roll = $urandom_range(99);
            if (roll < 15 && last_write < w * h) begin
               // hit the pixel just written: read-after-write in the pipe
               ix = (last_write % w) * 16 + int'($urandom_range(0, 15)) - 8;
               iy = (last_write / w) * 16 + int'($urandom_range(0, 15)) - 8;
            end else if (roll < 75) begin
               ix = int'($urandom_range(0, w * 16 - 1));
               iy = int'($urandom_range(0, h * 16 - 1));
            end else if (roll < 90) begin
               // around either edge of the frame, just inside or just outside
               ix = $urandom_range(1) ? int'($urandom_range(0, 63)) - 48
                                      : w * 16 - 32 + int'($urandom_range(0, 63));
               iy = $urandom_range(1) ? int'($urandom_range(0, 63)) - 48
                                      : h * 16 - 32 + int'($urandom_range(0, 63));
            end else begin
               ix = int'($urandom);
               iy = int'($urandom);
            end
            send_query(16'(ix), 16'(iy));
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // corners, dropped writes, rounding edges, clamping, back-to-back hazards
      send_write(19'd0, 16'hFFFF);
      send_write(19'd307199, 16'h0001);
      send_write(19'd307200, 16'h1234);
      send_write(19'h7FFFF, 16'hABCD);
      send_write(19'd639, 16'h0000);
      send_write(19'd306560, 16'h8000);
      send_query(16'sd0, 16'sd0);
      send_query(16'sh8000, 16'sh8000);
      send_query(16'sh7FFF, 16'sh7FFF);
      send_query(16'sd10231, 16'sd0);
      send_query(16'sd10232, 16'shFFFF);
      send_query(16'shFFFF, 16'sd7664);
      send_query(16'sd5098, 16'sd4085);
      send_query(16'sd24, 16'sd8);
      send_write(19'd0, 16'h0001);
      send_query(16'sd0, 16'sd0);
      send_write(19'd0, 16'h2222);
      send_write(19'd0, 16'h3333);
      send_query(16'sd7, -16'sd8);
      send_query(16'sh7FFF, 16'sd0);

      for (int phase = 1; phase <= 6; phase++) begin
         if (phase == 3) begin
            send_idle_pct = 50;
            recv_idle_pct = 12;
         end
         if (phase == 5) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (phase)
            1: load_camera(int'($urandom_range(16000, 80000)), int'($urandom_range(16000, 80000)),
                           int'($urandom_range(0, 1023)), int'($urandom_range(0, 767)),
                           int'($urandom_range(1000, 8000)), 16, 12);
            2: load_camera(24'hFFFFFF, 24'hFFFFFF, 0, 0, 24'hFFFFFF, 640, 480);
            3: load_camera(0, 0, 16'hFFFF, 16'hFFFF, 0, 0, 0);
            4: load_camera(int'($urandom_range(0, 24'hFFFFFF)), int'($urandom_range(0, 24'hFFFFFF)),
                           int'($urandom_range(0, 16'hFFFF)), int'($urandom_range(0, 16'hFFFF)),
                           int'($urandom_range(0, 24'hFFFFFF)), 1023, 511);
            5: load_camera(int'($urandom_range(16000, 80000)), int'($urandom_range(16000, 80000)),
                           int'($urandom_range(0, 16'hFFFF)), int'($urandom_range(0, 16'hFFFF)),
                           int'($urandom_range(0, 65535)), 1, 480);
            default: load_camera(int'($urandom_range(0, 24'hFFFFFF)),
                                 int'($urandom_range(0, 24'hFFFFFF)),
                                 int'($urandom_range(0, 16'hFFFF)), int'($urandom_range(0, 16'hFFFF)),
                                 int'($urandom_range(0, 24'hFFFFFF)),
                                 int'($urandom_range(1, 64)), int'($urandom_range(1, 48)));
         endcase
         random_items(PHASE_ITEMS);
      end

      wait_idle();
      $display("summary: %0d pixel writes and %0d point queries over %0d camera settings",
               sb.writes, sb.queries, settings);
      $display("summary: frame sizes 1 wide to out of range, saturated and zero Z and X/Y");
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
